/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while rst is high
`define CHK_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also active during reset
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/tcgr_pkg.sv */
package tcgr_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FORE_COLOR    = 3'd2;
  localparam logic [2:0] REG_BACK_COLOR    = 3'd3;
  localparam logic [2:0] REG_LEFT_MARGIN   = 3'd4;
  localparam logic [2:0] REG_TOP_MARGIN    = 3'd5;

  // reset values of the registers
  localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd720;
  localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd480;
  localparam logic [31:0] RST_FORE_COLOR    = 32'hffff_ffff;
  localparam logic [31:0] RST_BACK_COLOR    = 32'h0000_0000;
  localparam logic [7:0]  RST_LEFT_MARGIN   = 8'd40;
  localparam logic [7:0]  RST_TOP_MARGIN    = 8'd30;

  // item kinds
  localparam logic FUNC_PRINT = 1'b0;
  localparam logic FUNC_LOAD  = 1'b1;

  // control characters
  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_BS  = 8'd8;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;

  localparam logic [11:0] COORD_MAX  = 12'hfff;
  localparam logic [4:0]  CHAR_STEP  = 5'd8;
  localparam int          ADDR_W     = 22;
  localparam int          PIX_W      = 32;
  localparam int          ROW_PIXELS = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_VCHK,
    ST_MUL,
    ST_BASE,
    ST_ROWS
  } state_t;

  // screen geometry seen by the cursor logic
  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [7:0]  left_margin;
    logic [7:0]  top_margin;
  } geom_t;

  // travels with each font read to the output stage
  typedef struct packed {
    logic [ADDR_W-1:0] pixel_addr;
    logic              last_row;
    logic              blank;
  } row_tag_t;

endpackage

/* hdl/tcgr_font_mem.sv */
module tcgr_font_mem #(
  parameter int DEPTH = 3584,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/tcgr_ctrl.sv */
module tcgr_ctrl #(
  parameter int GLYPH_ROWS  = 14,
  parameter int GLYPH_COUNT = 256,
  parameter int AW          = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  tcgr_pkg::geom_t     geom,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                func,
  input  logic [7:0]          char_code,
  input  logic [3:0]          glyph_row,
  input  logic [7:0]          glyph_bits,
  input  logic                row_ready,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  output tcgr_pkg::row_tag_t  tag
);
  import tcgr_pkg::*;

  `include "assert_macros.svh"

  localparam int RW = $clog2(GLYPH_ROWS);
  localparam int MW = AW + 2;

  function automatic logic [11:0] sat_add(input logic [11:0] a, input logic [4:0] b);
    logic [12:0] s;
    s = {1'b0, a} + 13'(b);
    return s[12] ? COORD_MAX : s[11:0];
  endfunction

  state_t            state, state_next;
  logic [11:0]       cursor_x, cursor_x_next;
  logic [11:0]       cursor_y, cursor_y_next;
  logic [AW-1:0]     glyph_base;
  logic              blank;
  logic [ADDR_W-1:0] prod;
  logic [ADDR_W-1:0] pix_addr;
  logic [RW-1:0]     row_cnt;

  logic              acc;
  logic              is_last;
  logic [MW-1:0]     wr_sum;
  logic [MW-1:0]     base_sum;
  logic [14:0]       x_reach, x_limit, y_reach, y_limit;
  logic [12:0]       y_off;
  logic [24:0]       mul_full;

  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign is_last  = (row_cnt == RW'(GLYPH_ROWS - 1));

  // font load path
  assign wr_sum  = MW'(char_code) * MW'(GLYPH_ROWS) + MW'(glyph_row);
  assign wr_en   = acc && (func == FUNC_LOAD)
                   && ({1'b0, glyph_row} < 5'(GLYPH_ROWS))
                   && ({1'b0, char_code} < 9'(GLYPH_COUNT));
  assign wr_addr = wr_sum[AW-1:0];
  assign wr_data = glyph_bits;

  assign base_sum = MW'(char_code) * MW'(GLYPH_ROWS);

  // wrap and bottom checks, signed so oversized margins still compare sanely
  assign x_reach = 15'(cursor_x) + 15'(geom.left_margin) + 15'(GLYPH_ROWS);
  assign x_limit = 15'(geom.screen_width) - 15'(geom.left_margin);
  assign y_reach = 15'(cursor_y) + 15'(geom.top_margin) + 15'(GLYPH_ROWS);
  assign y_limit = 15'(geom.screen_height) - 15'(geom.top_margin);

  assign y_off    = 13'(cursor_y) + 13'(geom.top_margin);
  assign mul_full = 25'(y_off) * 25'(geom.screen_width);

  // font reads, one row per cycle while the output side has room
  assign rd_en           = (state == ST_ROWS) && row_ready;
  assign rd_addr         = glyph_base + AW'(row_cnt);
  assign tag.pixel_addr  = pix_addr;
  assign tag.last_row    = is_last;
  assign tag.blank       = blank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cursor_x <= '0;
      cursor_y <= '0;
    end else begin
      state    <= state_next;
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

  always_comb begin
    state_next    = state;
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    case (state)
      ST_IDLE: begin
        if (acc && func == FUNC_PRINT) begin
          case (char_code)
            CHAR_NUL: ;
            CHAR_CR: cursor_x_next = '0;
            CHAR_LF: cursor_y_next = sat_add(cursor_y, 5'(GLYPH_ROWS));
            CHAR_BS: begin
              cursor_x_next = (cursor_x >= 12'(CHAR_STEP))
                              ? cursor_x - 12'(CHAR_STEP) : '0;
            end
            default: state_next = ST_WRAP;
          endcase
        end
      end
      ST_WRAP: begin
        if ($signed(x_reach) > $signed(x_limit)) begin
          cursor_x_next = '0;
          cursor_y_next = sat_add(cursor_y, 5'(GLYPH_ROWS));
        end
        state_next = ST_VCHK;
      end
      ST_VCHK: begin
        if ($signed(y_reach) > $signed(y_limit)) begin
          cursor_y_next = '0;
        end
        state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_BASE;
      ST_BASE: state_next = ST_ROWS;
      ST_ROWS: begin
        if (rd_en && is_last) begin
          cursor_x_next = sat_add(cursor_x, CHAR_STEP);
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      glyph_base <= base_sum[AW-1:0];
      blank      <= ({1'b0, char_code} >= 9'(GLYPH_COUNT));
    end
    if (state == ST_MUL) begin
      prod <= mul_full[ADDR_W-1:0];
    end
    if (state == ST_BASE) begin
      pix_addr <= prod + ADDR_W'(cursor_x) + ADDR_W'(geom.left_margin);
      row_cnt  <= '0;
    end else if (rd_en) begin
      pix_addr <= pix_addr + ADDR_W'(geom.screen_width);
      row_cnt  <= row_cnt + 1'b1;
    end
  end

  `CHK_ALWAYS(a_no_rw_overlap, !(wr_en && rd_en), "font write and read in the same cycle")
  `CHK_SYNC(a_last_to_idle, (rd_en && is_last) |=> (state == ST_IDLE), "no return to idle")
  `CHK_SYNC(a_row_hold, (state == ST_ROWS && !row_ready) |=> $stable(row_cnt) && $stable(pix_addr), "row advanced while stalled")

endmodule

/* hdl/text_console_glyph_renderer_unit.sv */
// Text console character generator. Print items (tuser = 0) move a pixel
// cursor or draw one character; load items (tuser = 1) write one row of the
// 8-pixel-wide font into the internal font memory, which powers up undefined
// and must be loaded before a glyph is printed. A load or a control character
// (NUL, CR, LF, backspace) leaves the block idle and ready for the next item.
// A printable character holds off the next item through the cursor wrap check,
// bottom check, address multiply and base address steps, then one font memory
// read per glyph row; rows leave at one per cycle while m_tready stays high.
// The font memory's single read port sets that row rate. Rows finish draining
// through a two-deep output path while the next item is already accepted.
// Each row carries its framebuffer pixel offset and eight fore or back colored
// pixels, leftmost first, with tlast on the final row. Configuration must be
// written only while no character is in flight; the block does not enforce it.
module text_console_glyph_renderer_unit #(
  parameter int GLYPH_ROWS  = 14,
  parameter int GLYPH_COUNT = 256
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // char_code[7:0], glyph_row[11:8], glyph_bits[19:12]
  input  logic [0:0]   s_tuser,   // func[0]
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [279:0] m_tdata,   // pixel_addr[21:0], pixel_0 .. pixel_7 at 32 bits each
  output logic         m_tlast,   // last_row
  // configuration writes
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import tcgr_pkg::*;

  localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int AW    = $clog2(DEPTH);

  // configuration registers
  geom_t       geom;
  logic [31:0] fore_color;
  logic [31:0] back_color;

  // font memory hookup
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;
  row_tag_t      tag;

  // read stage: the font byte is in rd_data while pend is set
  logic     pend;
  row_tag_t pend_tag;
  logic     out_free;
  logic     row_ready;
  logic [7:0] glyph;

  // output register
  logic [ADDR_W-1:0] out_addr;
  logic [PIX_W-1:0]  out_pix [ROW_PIXELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.screen_width  <= RST_SCREEN_WIDTH;
      geom.screen_height <= RST_SCREEN_HEIGHT;
      geom.left_margin   <= RST_LEFT_MARGIN;
      geom.top_margin    <= RST_TOP_MARGIN;
      fore_color         <= RST_FORE_COLOR;
      back_color         <= RST_BACK_COLOR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  geom.screen_width  <= cfg_data[11:0];
        REG_SCREEN_HEIGHT: geom.screen_height <= cfg_data[11:0];
        REG_FORE_COLOR:    fore_color         <= cfg_data;
        REG_BACK_COLOR:    back_color         <= cfg_data;
        REG_LEFT_MARGIN:   geom.left_margin   <= cfg_data[7:0];
        REG_TOP_MARGIN:    geom.top_margin    <= cfg_data[7:0];
        default: ;  // unmapped indexes are dropped
      endcase
    end
  end

  tcgr_ctrl #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT),
    .AW          (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .func       (s_tuser[0]),
    .char_code  (s_tdata[7:0]),
    .glyph_row  (s_tdata[11:8]),
    .glyph_bits (s_tdata[19:12]),
    .row_ready  (row_ready),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .tag        (tag)
  );

  // loads and reads never meet: loads only while idle, reads only while drawing
  tcgr_font_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_font (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register empties this edge or is empty already
  assign out_free  = !m_tvalid || m_tready;
  // a new read may start when the read stage is empty or moves on this edge
  assign row_ready = !pend || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (rd_en) begin
      pend <= 1'b1;
    end else if (out_free) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_tag <= tag;
    end
  end

  // codes beyond the font draw as an all-clear glyph
  assign glyph = pend_tag.blank ? 8'h00 : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= pend;
    end
  end

  // expand the glyph row, bit 7 is the leftmost pixel
  always_ff @(posedge clk) begin
    if (out_free && pend) begin
      out_addr <= pend_tag.pixel_addr;
      m_tlast  <= pend_tag.last_row;
      for (int j = 0; j < ROW_PIXELS; j++) begin
        out_pix[j] <= glyph[ROW_PIXELS-1-j] ? fore_color : back_color;
      end
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[ADDR_W-1:0] = out_addr;
    for (int j = 0; j < ROW_PIXELS; j++) begin
      m_tdata[ADDR_W + j*PIX_W +: PIX_W] = out_pix[j];
    end
  end

endmodule

/* tb/text_console_glyph_renderer_unit_tb.sv */
`timescale 1ns / 100ps

module text_console_glyph_renderer_unit_tb;
  import tcgr_pkg::*;

  localparam int GLYPH_ROWS = 14;
  localparam int GLYPH_COUNT = 256;
  // slack after the last row: cursor pipeline plus the two-deep output path
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  // one console transaction on the input stream
  typedef struct packed {
    logic       func;
    logic [7:0] code;
    logic [3:0] grow;
    logic [7:0] bits;
  } console_item_t;

  // one glyph row as it should leave the block
  typedef struct packed {
    logic [21:0]      addr;
    logic [7:0][31:0] pix;
    logic             last;
  } glyph_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [23:0]  s_tdata = '0;   // char_code[7:0], glyph_row[11:8], glyph_bits[19:12]
  logic [0:0]   s_tuser = '0;   // func[0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [279:0] m_tdata;        // pixel_addr[21:0], pixel_0 .. pixel_7 at 32 bits each
  logic         m_tlast;        // last_row
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  text_console_glyph_renderer_unit #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .GLYPH_COUNT(GLYPH_COUNT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the register file, kept in step with every write
  int          scr_w = RST_SCREEN_WIDTH;
  int          scr_h = RST_SCREEN_HEIGHT;
  logic [31:0] ink_color = RST_FORE_COLOR;
  logic [31:0] paper_color = RST_BACK_COLOR;
  int          margin_x = RST_LEFT_MARGIN;
  int          margin_y = RST_TOP_MARGIN;

  // predicted console state
  int         cur_x = 0;
  int         cur_y = 0;
  logic [7:0] font_copy [GLYPH_COUNT][GLYPH_ROWS];

  // stimulus-side bookkeeping: which glyphs are fully loaded and safe to print
  logic [GLYPH_ROWS-1:0] rows_loaded [GLYPH_COUNT];
  bit                    printable [GLYPH_COUNT];
  int                    ready_codes [$];

  console_item_t items_to_send [$];
  glyph_row_t    rows_due [$];
  console_item_t held_item;
  bit            item_held = 1'b0;

  int cyc_count = 0;
  int fail_count = 0;
  int items_sent = 0;
  int rows_checked = 0;
  int line_wraps = 0;
  int page_resets = 0;
  int settings_run = 1;

  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_timer = 0;

  function automatic int add_rows_sat(input int v);
    return (v + GLYPH_ROWS > COORD_MAX) ? int'(COORD_MAX) : v + GLYPH_ROWS;
  endfunction

  // apply one accepted transaction to the predicted state and queue its rows
  task automatic advance_console(input console_item_t it);
    glyph_row_t row;
    logic [7:0] g;
    int         base;
    if (it.func == FUNC_LOAD) begin
      // rows past the glyph height are dropped
      if (it.grow < GLYPH_ROWS) font_copy[it.code][it.grow] = it.bits;
      return;
    end
    case (it.code)
      CHAR_NUL: ;
      CHAR_CR:  cur_x = 0;
      CHAR_LF:  cur_y = add_rows_sat(cur_y);
      CHAR_BS:  cur_x = (cur_x >= CHAR_STEP) ? cur_x - CHAR_STEP : 0;
      default: begin
        // signed compares: a screen narrower than its margins wraps every time
        if (cur_x + margin_x + GLYPH_ROWS > scr_w - margin_x) begin
          cur_y = add_rows_sat(cur_y);
          cur_x = 0;
          line_wraps++;
        end
        if (cur_y + margin_y + GLYPH_ROWS > scr_h - margin_y) begin
          cur_y = 0;
          page_resets++;
        end
        base = (cur_y + margin_y) * scr_w + cur_x + margin_x;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          g = font_copy[it.code][r];
          row.addr = 22'(base + r * scr_w);
          for (int j = 0; j < ROW_PIXELS; j++)
            row.pix[j] = g[7-j] ? ink_color : paper_color;
          row.last = (r == GLYPH_ROWS - 1);
          rows_due.push_back(row);
        end
        cur_x = (cur_x + CHAR_STEP > COORD_MAX) ? int'(COORD_MAX) : cur_x + CHAR_STEP;
      end
    endcase
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin : sender
    bit go;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        advance_console(held_item);
        item_held = 1'b0;
        items_sent++;
      end
      if (!item_held) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (items_to_send.size() > 0) begin
          held_item = items_to_send.pop_front();
          item_held = 1'b1;
          go = 1'b1;
          s_tdata <= {4'b0, held_item.bits, held_item.grow, held_item.code};
          s_tuser <= held_item.func;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            // long back-to-back stretch
            burst_left = $urandom_range(40, 80);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                   : $urandom_range(1, 6);
          end
        end
        s_tvalid <= go;
      end
    end
  end

  // receiver: stall pattern switches after a random stretch
  always @(posedge clk) begin : receiver
    bit rdy;
    if (!rst) begin
      if (stall_timer == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_timer = $urandom_range(50, 300);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 2) != 0);
        2:       rdy = (cyc_count[2:0] > 3'd2);
        default: rdy = (cyc_count[4:3] == 2'd0);   // long stalls
      endcase
      m_tready <= rdy;
    end
  end

  // row checker: every output transaction against the oldest prediction
  always @(posedge clk) begin : row_checker
    glyph_row_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (rows_due.size() == 0) begin
        $error("unexpected glyph row, pixel_addr %0h", m_tdata[21:0]);
        fail_count++;
      end else begin
        want = rows_due.pop_front();
        rows_checked++;
        if (m_tdata[21:0] !== want.addr) begin
          $error("pixel_addr mismatch: expected %0h, got %0h", want.addr, m_tdata[21:0]);
          fail_count++;
        end
        for (int j = 0; j < ROW_PIXELS; j++) begin
          if (m_tdata[22+32*j +: 32] !== want.pix[j]) begin
            $error("pixel_%0d mismatch: expected %h, got %h", j, want.pix[j],
                   m_tdata[22+32*j +: 32]);
            fail_count++;
          end
        end
        if (m_tlast !== want.last) begin
          $error("last_row mismatch: expected %0b, got %0b", want.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc_count++;
    if (cyc_count > CYCLE_LIMIT) begin
      $display("[text_console_glyph_renderer_unit] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  scr_w = val[11:0];
      REG_SCREEN_HEIGHT: scr_h = val[11:0];
      REG_FORE_COLOR:    ink_color = val;
      REG_BACK_COLOR:    paper_color = val;
      REG_LEFT_MARGIN:   margin_x = val[7:0];
      REG_TOP_MARGIN:    margin_y = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_screen(input int w, input int h, input logic [31:0] fg,
                            input logic [31:0] bg, input int lm, input int tm);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_FORE_COLOR, fg);
    write_reg(REG_BACK_COLOR, bg);
    write_reg(REG_LEFT_MARGIN, lm);
    write_reg(REG_TOP_MARGIN, tm);
    settings_run++;
  endtask

  // hold off until the block has nothing left in flight
  task automatic wait_drained();
    while (items_to_send.size() != 0 || item_held || rows_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_load(input logic [7:0] code, input logic [3:0] grow,
                           input logic [7:0] bits);
    console_item_t it;
    it = '{func: FUNC_LOAD, code: code, grow: grow, bits: bits};
    items_to_send.push_back(it);
    if (grow < GLYPH_ROWS) rows_loaded[code][grow] = 1'b1;
    // a glyph becomes printable once all its rows are in
    if (&rows_loaded[code] && !printable[code] && code != CHAR_NUL && code != CHAR_CR &&
        code != CHAR_LF && code != CHAR_BS) begin
      printable[code] = 1'b1;
      ready_codes.push_back(code);
    end
  endtask

  task automatic push_char(input logic [7:0] code);
    console_item_t it;
    it = '{func: FUNC_PRINT, code: code, grow: 4'($urandom_range(0, 15)),
           bits: 8'($urandom_range(0, 255))};
    items_to_send.push_back(it);
  endtask

  // whole glyph, rows in rotated order, bitmaps biased toward empty and solid rows
  task automatic load_glyph(input logic [7:0] code);
    int         rot;
    logic [7:0] bits;
    rot = $urandom_range(0, GLYPH_ROWS - 1);
    for (int k = 0; k < GLYPH_ROWS; k++) begin
      case ($urandom_range(0, 5))
        0:       bits = 8'h00;
        1:       bits = 8'hff;
        default: bits = 8'($urandom_range(0, 255));
      endcase
      push_load(code, 4'((k + rot) % GLYPH_ROWS), bits);
    end
  endtask

  // mostly printable characters, with glyph loads, control codes and stray rows
  task automatic random_mix(input int n);
    int k;
    int sel;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 7) begin
        load_glyph(8'($urandom_range(1, 255)));
        k += GLYPH_ROWS;
      end else if (sel < 13) begin
        push_load(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)));
        k++;
      end else if (sel < 27) begin
        case ($urandom_range(0, 4))
          0:       push_char(CHAR_NUL);
          1:       push_char(CHAR_CR);
          2:       push_char(CHAR_BS);
          default: push_char(CHAR_LF);
        endcase
        k++;
      end else begin
        push_char(8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]));
        k++;
      end
    end
  endtask

  initial begin
    for (int c = 0; c < GLYPH_COUNT; c++) begin
      rows_loaded[c] = '0;
      printable[c] = 1'b0;
      for (int r = 0; r < GLYPH_ROWS; r++) font_copy[c][r] = 8'h00;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: font set-up, then the directed cases
    load_glyph(8'h01);
    load_glyph(8'h55);
    load_glyph(8'haa);
    load_glyph(8'hff);
    push_load(8'h01, 4'd15, 8'hff);    // row beyond glyph height, ignored
    push_load(8'hff, 4'd14, 8'h00);    // first row past the end, ignored
    push_load(8'h55, 4'd5, 8'hff);     // overwrite one row with a solid row
    push_load(8'haa, 4'd9, 8'h00);
    push_load(CHAR_NUL, 4'd13, 8'hff); // glyph of a control code, never drawn
    push_char(8'h01);
    push_char(8'hff);
    push_char(8'h55);
    push_char(8'haa);
    push_char(CHAR_BS);
    push_char(CHAR_CR);
    push_char(CHAR_BS);                // backspace at the left edge stays at zero
    push_char(CHAR_NUL);
    push_char(8'hff);
    push_char(CHAR_LF);
    push_char(8'h55);
    push_char(CHAR_LF);
    push_char(CHAR_CR);
    push_char(8'haa);
    random_mix(80);
    wait_drained();

    // largest screen, no margins: addresses reach the top of the 22-bit range
    set_screen(2048, 2048, $urandom, $urandom, 0, 0);
    random_mix(30);
    // a long run of line feeds far down the page before the next glyph
    repeat (40) push_char(CHAR_LF);
    push_char(8'(ready_codes[0]));
    random_mix(20);
    wait_drained();

    // smallest screen with widest margins: wrap and page reset on every glyph
    set_screen(16, 16, 32'h0000_0000, 32'hffff_ffff, 255, 255);
    random_mix(30);
    wait_drained();

    // random geometry with moderate margins
    set_screen($urandom_range(16, 2048), $urandom_range(16, 2048), $urandom, $urandom,
               $urandom_range(0, 60), $urandom_range(0, 60));
    random_mix(40);
    wait_drained();

    // fully random geometry; sender pauses midway until every row is back
    set_screen($urandom_range(16, 2048), $urandom_range(16, 2048), $urandom, $urandom,
               $urandom_range(0, 255), $urandom_range(0, 255));
    random_mix(20);
    wait_drained();
    random_mix(20);
    wait_drained();

    $display("%0d console items over %0d screen settings, %0d glyph rows checked",
             items_sent, settings_run, rows_checked);
    $display("%0d line wraps and %0d page resets predicted", line_wraps, page_resets);
    if (fail_count == 0) begin
      $display("[text_console_glyph_renderer_unit] OK");
    end else begin
      $display("[text_console_glyph_renderer_unit] ERROR");
    end
    $finish;
  end

endmodule
